### hdl/sophia_optimizer_update_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the optimizer update engine.
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SOPHIA_OPTIMIZER_UPDATE_ASSERT_SVH
`define SOPHIA_OPTIMIZER_UPDATE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SOU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sou: implication check failed");

// Next-cycle implication, disabled during reset.
`define SOU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sou: next-cycle check failed");

`endif

### hdl/sou_pkg.sv
// ----------------------------------------------------------------------------
// sou_pkg
// Shared constants, payload types and fixed-point helpers for the
// second-order clipped optimizer update engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sou_pkg;

  // Store geometry and number format.
  localparam int DEPTH       = 4096;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int FRAC_W      = 24;
  localparam int QUEUE_DEPTH = 4;

  // Divider: one quotient bit per stage plus one setup stage.
  localparam int DIV_STEPS = 33;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEARNING_RATE   = 3'd0;
  localparam logic [2:0] REG_BETA_ONE        = 3'd1;
  localparam logic [2:0] REG_BETA_TWO        = 3'd2;
  localparam logic [2:0] REG_CURVATURE_FLOOR = 3'd3;
  localparam logic [2:0] REG_CLIP_LIMIT      = 3'd4;
  localparam logic [2:0] REG_DECAY_RATE      = 3'd5;
  localparam logic [2:0] REG_BIAS_CORRECTION = 3'd6;

  // Word limits and the value 1.0.
  localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;
  localparam logic signed [25:0] ONE_Q    = 26'sd16777216;

  typedef struct packed {
    logic [IDX_W-1:0]   element_index;
    logic               mode;
    logic signed [31:0] gradient;
    logic signed [31:0] param_value;
    logic signed [31:0] hessian_diag;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   result_index;
    logic signed [31:0] new_param;
    logic signed [31:0] new_momentum;
    logic signed [31:0] new_curvature;
    logic               was_clipped;
  } result_t;

  typedef struct packed {
    logic [24:0] learning_rate;
    logic [24:0] beta_one;
    logic [24:0] beta_two;
    logic [24:0] curvature_floor;
    logic [30:0] clip_limit;
    logic [24:0] decay_rate;
    logic [24:0] bias_correction;
  } cfg_t;

  // Item after front-end classification: all state-free products done.
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] param;
    logic signed [31:0] gm_term;
    logic signed [31:0] h_term;
    logic signed [31:0] d_term;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Saturate a wide signed value to the 32-bit word range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > WORD_MAX) begin
      return WORD_MAX[31:0];
    end else if (v < WORD_MIN) begin
      return WORD_MIN[31:0];
    end
    return v[31:0];
  endfunction

  // Rescale a raw product: floor division by 2^FRAC_W, then saturate.
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FRAC_W;
    return sat32(s);
  endfunction

endpackage

`default_nettype wire

### hdl/sou_front.sv
// ----------------------------------------------------------------------------
// sou_front
// Accepts items, selects the curvature source by mode and forms every
// product that does not depend on the state stores.
// ----------------------------------------------------------------------------
`default_nettype none

module sou_front (
  input  logic                  clk,
  input  logic                  rst,
  input  sou_pkg::cfg_t         cfg,
  input  sou_pkg::back_status_t status,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  sou_pkg::item_t        item,
  output logic                  push_valid,
  input  logic                  push_ready,
  output sou_pkg::entry_t       push_data
);
  import sou_pkg::*;

  logic               f1_v;
  item_t              f1;
  logic               f2_v;
  logic [IDX_W-1:0]   f2_idx;
  logic               f2_mode;
  logic signed [31:0] f2_hx;
  logic signed [31:0] f2_p;
  logic signed [31:0] f2_gm;
  logic signed [31:0] f2_gg;
  logic signed [31:0] f2_dt;

  logic               f1_adv;
  logic               f2_adv;
  logic signed [25:0] one_m_b1;
  logic signed [25:0] one_m_b2;
  logic signed [57:0] prod_gm;
  logic signed [63:0] prod_gg;
  logic signed [57:0] prod_dt;
  logic signed [31:0] hd;
  logic signed [57:0] prod_h;

  // Stage handshake: a stage moves when the one after it has room.
  assign f2_adv     = !f2_v || push_ready;
  assign f1_adv     = !f1_v || f2_adv;
  assign item_ready = f1_adv && !status.clearing;
  assign push_valid = f2_v;

  // First stage products: momentum input term, squared gradient, decay term.
  assign one_m_b1 = ONE_Q - $signed({1'b0, cfg.beta_one});
  assign prod_gm  = one_m_b1 * $signed(f1.gradient);
  assign prod_gg  = $signed(f1.gradient) * $signed(f1.gradient);
  assign prod_dt  = $signed({1'b0, cfg.decay_rate}) * $signed(f1.param_value);

  // Second stage: choose the curvature sample and weight it.
  assign one_m_b2 = ONE_Q - $signed({1'b0, cfg.beta_two});
  assign hd       = f2_mode ? f2_hx : f2_gg;
  assign prod_h   = one_m_b2 * hd;

  assign push_data.idx     = f2_idx;
  assign push_data.param   = f2_p;
  assign push_data.gm_term = f2_gm;
  assign push_data.h_term  = qscale(64'(prod_h));
  assign push_data.d_term  = f2_dt;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (f1_adv) begin
      f1_v <= item_valid && !status.clearing;
    end
    if (f1_adv) begin
      f1 <= item;
    end
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (f2_adv) begin
      f2_v <= f1_v;
    end
    if (f2_adv) begin
      f2_idx  <= f1.element_index;
      f2_mode <= f1.mode;
      f2_hx   <= f1.hessian_diag;
      f2_p    <= f1.param_value;
      f2_gm   <= qscale(64'(prod_gm));
      f2_gg   <= qscale(prod_gg);
      f2_dt   <= qscale(64'(prod_dt));
    end
  end

endmodule

`default_nettype wire

### hdl/sou_queue.sv
// ----------------------------------------------------------------------------
// sou_queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sou_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  sou_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sou_pkg::entry_t pop_data
);
  import sou_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hdl/sou_div.sv
// ----------------------------------------------------------------------------
// sou_div
// Pipelined restoring divider: floor(num * 2^24 / den) for unsigned operands,
// one quotient bit per stage, with an overflow flag for quotients of 2^33
// and above.
// ----------------------------------------------------------------------------
`default_nettype none

module sou_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [32:0] quo,
  output logic        ovf
);
  import sou_pkg::*;

  logic [31:0] rem_s  [DIV_LAT];
  logic [32:0] rest_s [DIV_LAT];
  logic [32:0] quo_s  [DIV_LAT];
  logic [31:0] den_s  [DIV_LAT];
  logic        ovf_s  [DIV_LAT];

  // Setup: overflow test and the leading dividend bits as first remainder.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_s[0]  <= {9'b0, num} >= {den, 9'b0};
      rem_s[0]  <= {9'b0, num[31:9]};
      rest_s[0] <= {num[8:0], 24'b0};
      quo_s[0]  <= '0;
      den_s[0]  <= den;
    end
  end

  // One shift, compare and subtract per stage.
  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    assign trial = {rem_s[k-1], rest_s[k-1][32]};
    assign diff  = trial - {1'b0, den_s[k-1]};
    assign fits  = trial >= {1'b0, den_s[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k]  <= fits ? diff[31:0] : trial[31:0];
        rest_s[k] <= {rest_s[k-1][31:0], 1'b0};
        quo_s[k]  <= {quo_s[k-1][31:0], fits};
        den_s[k]  <= den_s[k-1];
        ovf_s[k]  <= ovf_s[k-1];
      end
    end
  end

  assign quo = quo_s[DIV_LAT-1];
  assign ovf = ovf_s[DIV_LAT-1];

endmodule

`default_nettype wire

### hdl/sou_back.sv
// ----------------------------------------------------------------------------
// sou_back
// Reads and updates the momentum and curvature stores, then forms the
// bias-corrected ratio, clips it and produces the new parameter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sophia_optimizer_update_assert.svh"

module sou_back (
  input  logic                  clk,
  input  logic                  rst,
  input  sou_pkg::cfg_t         cfg,
  output sou_pkg::back_status_t status,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  sou_pkg::entry_t       pop_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output sou_pkg::result_t      result
);
  import sou_pkg::*;

  localparam int CLR_W = IDX_W + 1;

  typedef struct packed {
    logic               v;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] p;
    logic signed [31:0] dt;
    logic signed [31:0] m;
    logic signed [31:0] h;
    logic signed [31:0] dv;
    logic               neg;
  } ctx_t;

  logic signed [31:0] mom_mem [DEPTH];
  logic signed [31:0] cur_mem [DEPTH];

  logic [CLR_W-1:0]   clr_cnt;
  logic               clearing;
  logic               adv;
  logic               hazard;
  logic               pop;

  logic               s1_v;
  entry_t             s1;
  logic signed [31:0] rd_m;
  logic signed [31:0] rd_h;
  logic signed [57:0] prod_m;
  logic signed [57:0] prod_h;

  logic               s2_v;
  entry_t             s2;
  logic signed [31:0] s2_pm;
  logic signed [31:0] s2_ph;
  logic signed [31:0] m_new;
  logic signed [31:0] h_new;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [31:0] wr_m;
  logic signed [31:0] wr_h;

  ctx_t               s3;
  ctx_t               s3_out;
  logic signed [31:0] fl_eff;
  logic [24:0]        bc_eff;
  logic [31:0]        num1;
  logic [32:0]        q1;
  logic               ovf1;
  ctx_t               pa [DIV_LAT];
  logic signed [31:0] mh;

  ctx_t               s4;
  logic signed [31:0] s4_mh;
  logic [31:0]        num2;
  logic [32:0]        q2;
  logic               ovf2;
  ctx_t               pb [DIV_LAT];
  logic               clip;
  logic [30:0]        mag;
  logic signed [31:0] ratio;

  ctx_t               s5;
  logic signed [31:0] s5_ratio;
  logic               s5_clip;
  ctx_t               s6;
  logic signed [31:0] s6_upd;
  logic               s6_clip;
  logic signed [57:0] prod_lr;
  ctx_t               s7;
  logic signed [31:0] s7_pq;
  logic               s7_clip;

  // Clearing pass over both stores after reset.
  assign clearing        = clr_cnt != CLR_W'(DEPTH);
  assign status.clearing = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // The whole back pipeline moves when the result register can take a value.
  assign adv = !result_valid || result_ready;

  // Hold the queue head while an older item on the same element has not
  // yet written its store entries.
  assign hazard    = (s1_v && s1.idx == pop_data.idx) ||
                     (s2_v && s2.idx == pop_data.idx);
  assign pop_ready = adv && !clearing && !hazard;
  assign pop       = pop_valid && pop_ready;

  // Store read port, registered.
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_m <= mom_mem[pop_data.idx];
      rd_h <= cur_mem[pop_data.idx];
    end
  end

  // Store write port: clearing pass or update from the averaging stage.
  assign m_new   = sat32(64'(s2_pm) + 64'($signed(s2.gm_term)));
  assign h_new   = sat32(64'(s2_ph) + 64'($signed(s2.h_term)));
  assign wr_en   = clearing || (adv && s2_v);
  assign wr_addr = clearing ? clr_cnt[IDX_W-1:0] : s2.idx;
  assign wr_m    = clearing ? '0 : m_new;
  assign wr_h    = clearing ? '0 : h_new;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mom_mem[wr_addr] <= wr_m;
      cur_mem[wr_addr] <= wr_h;
    end
  end

  // Decay of the stored averages.
  assign prod_m = $signed({1'b0, cfg.beta_one}) * rd_m;
  assign prod_h = $signed({1'b0, cfg.beta_two}) * rd_h;

  // Effective divisors: a zero register acts as the smallest step.
  assign bc_eff = (cfg.bias_correction == '0) ? 25'd1 : cfg.bias_correction;
  assign fl_eff = (cfg.curvature_floor == '0) ? 32'sd1
                                              : $signed({7'b0, cfg.curvature_floor});

  // Divisor for the ratio and magnitude for the bias correction.
  always_comb begin
    s3_out    = s3;
    s3_out.dv = (s3.h > fl_eff) ? s3.h : fl_eff;
    s3_out.neg = s3.m < 0;
  end
  assign num1 = s3.m[31] ? 32'(-s3.m) : s3.m;

  sou_div u_div_bias (
    .clk (clk),
    .en  (adv),
    .num (num1),
    .den ({7'b0, bc_eff}),
    .quo (q1),
    .ovf (ovf1)
  );

  // Signed, saturated bias-corrected momentum.
  always_comb begin
    if (!pa[DIV_LAT-1].neg) begin
      mh = (ovf1 || q1[32:31] != 2'b00) ? WORD_MAX[31:0] : q1[31:0];
    end else begin
      mh = (ovf1 || q1 > 33'h080000000) ? WORD_MIN[31:0] : -q1[31:0];
    end
  end

  assign num2 = s4_mh[31] ? 32'(-s4_mh) : s4_mh;

  sou_div u_div_ratio (
    .clk (clk),
    .en  (adv),
    .num (num2),
    .den (s4.dv),
    .quo (q2),
    .ovf (ovf2)
  );

  // Clip the ratio magnitude and restore the sign.
  assign clip  = ovf2 || (q2 > {2'b00, cfg.clip_limit});
  assign mag   = clip ? cfg.clip_limit : q2[30:0];
  assign ratio = pb[DIV_LAT-1].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  assign prod_lr = $signed({1'b0, cfg.learning_rate}) * s6_upd;

  // Pipeline valid bits, then the payload that travels with them.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3.v         <= 1'b0;
      s4.v         <= 1'b0;
      s5.v         <= 1'b0;
      s6.v         <= 1'b0;
      s7.v         <= 1'b0;
      result_valid <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) begin
        pa[k].v <= 1'b0;
        pb[k].v <= 1'b0;
      end
    end else if (adv) begin
      s1_v         <= pop;
      s2_v         <= s1_v;
      s3.v         <= s2_v;
      pa[0].v      <= s3.v;
      s4.v         <= pa[DIV_LAT-1].v;
      pb[0].v      <= s4.v;
      s5.v         <= pb[DIV_LAT-1].v;
      s6.v         <= s5.v;
      s7.v         <= s6.v;
      result_valid <= s7.v;
      for (int k = 1; k < DIV_LAT; k++) begin
        pa[k].v <= pa[k-1].v;
        pb[k].v <= pb[k-1].v;
      end
    end

    if (adv) begin
      s1    <= pop_data;
      s2    <= s1;
      s2_pm <= qscale(64'(prod_m));
      s2_ph <= qscale(64'(prod_h));

      s3.idx <= s2.idx;
      s3.p   <= s2.param;
      s3.dt  <= s2.d_term;
      s3.m   <= m_new;
      s3.h   <= h_new;
      s3.dv  <= '0;
      s3.neg <= 1'b0;

      pa[0].idx <= s3_out.idx;
      pa[0].p   <= s3_out.p;
      pa[0].dt  <= s3_out.dt;
      pa[0].m   <= s3_out.m;
      pa[0].h   <= s3_out.h;
      pa[0].dv  <= s3_out.dv;
      pa[0].neg <= s3_out.neg;
      for (int k = 1; k < DIV_LAT; k++) begin
        pa[k].idx <= pa[k-1].idx;
        pa[k].p   <= pa[k-1].p;
        pa[k].dt  <= pa[k-1].dt;
        pa[k].m   <= pa[k-1].m;
        pa[k].h   <= pa[k-1].h;
        pa[k].dv  <= pa[k-1].dv;
        pa[k].neg <= pa[k-1].neg;
      end

      s4.idx <= pa[DIV_LAT-1].idx;
      s4.p   <= pa[DIV_LAT-1].p;
      s4.dt  <= pa[DIV_LAT-1].dt;
      s4.m   <= pa[DIV_LAT-1].m;
      s4.h   <= pa[DIV_LAT-1].h;
      s4.dv  <= pa[DIV_LAT-1].dv;
      s4.neg <= mh[31];
      s4_mh  <= mh;

      pb[0].idx <= s4.idx;
      pb[0].p   <= s4.p;
      pb[0].dt  <= s4.dt;
      pb[0].m   <= s4.m;
      pb[0].h   <= s4.h;
      pb[0].dv  <= s4.dv;
      pb[0].neg <= s4.neg;
      for (int k = 1; k < DIV_LAT; k++) begin
        pb[k].idx <= pb[k-1].idx;
        pb[k].p   <= pb[k-1].p;
        pb[k].dt  <= pb[k-1].dt;
        pb[k].m   <= pb[k-1].m;
        pb[k].h   <= pb[k-1].h;
        pb[k].dv  <= pb[k-1].dv;
        pb[k].neg <= pb[k-1].neg;
      end

      s5.idx   <= pb[DIV_LAT-1].idx;
      s5.p     <= pb[DIV_LAT-1].p;
      s5.dt    <= pb[DIV_LAT-1].dt;
      s5.m     <= pb[DIV_LAT-1].m;
      s5.h     <= pb[DIV_LAT-1].h;
      s5.dv    <= pb[DIV_LAT-1].dv;
      s5.neg   <= pb[DIV_LAT-1].neg;
      s5_ratio <= ratio;
      s5_clip  <= clip;

      s6.idx  <= s5.idx;
      s6.p    <= s5.p;
      s6.dt   <= s5.dt;
      s6.m    <= s5.m;
      s6.h    <= s5.h;
      s6.dv   <= s5.dv;
      s6.neg  <= s5.neg;
      s6_upd  <= sat32(64'(s5_ratio) + 64'(s5.dt));
      s6_clip <= s5_clip;

      s7.idx  <= s6.idx;
      s7.p    <= s6.p;
      s7.dt   <= s6.dt;
      s7.m    <= s6.m;
      s7.h    <= s6.h;
      s7.dv   <= s6.dv;
      s7.neg  <= s6.neg;
      s7_pq   <= qscale(64'(prod_lr));
      s7_clip <= s6_clip;

      result.result_index  <= s7.idx;
      result.new_param     <= sat32(64'(s7.p) - 64'(s7_pq));
      result.new_momentum  <= s7.m;
      result.new_curvature <= s7.h;
      result.was_clipped   <= s7_clip;
    end
  end

  // An item update never lands in the stores while they are being cleared.
  `SOU_ASSERT_IMPL(a_no_update_while_clearing, adv && s2_v, !clearing)
  // The pipeline holds no work while the clearing pass runs.
  `SOU_ASSERT_IMPL(a_empty_while_clearing, clearing, !s1_v && !s2_v && !result_valid)
  // The clearing pass runs once after reset.
  `SOU_ASSERT_NEXT(a_clear_once, !clearing, !clearing)

endmodule

`default_nettype wire

### hdl/sophia_optimizer_update.sv
// ----------------------------------------------------------------------------
// sophia_optimizer_update
// Second-order clipped optimizer step for one weight element per transfer,
// with per-element momentum and curvature stores.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  item      item_valid, item_ready, item              in
//  result    result_valid, result_ready, result        out
//  config    cfg_write, cfg_index, cfg_data            in
//
//  One item is taken per cycle unless the clearing pass or a full queue holds
//  it off; each result passes through the two 33-step divider pipelines.
//  An item whose element matches one of the two items ahead of it at the
//  store read waits at the queue head until their store writes are done.
//  After reset a clearing pass zeroes all 4096 entries of both stores,
//  during which item_ready is low.
//  A stalled result holds the back pipeline; the front end and the queue
//  keep taking items until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sophia_optimizer_update (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [30:0]      cfg_data,
  input  logic             item_valid,
  output logic             item_ready,
  input  sou_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output sou_pkg::result_t result
);
  import sou_pkg::*;

  cfg_t         cfg;
  back_status_t status;
  logic         push_valid;
  logic         push_ready;
  entry_t       push_data;
  logic         pop_valid;
  logic         pop_ready;
  entry_t       pop_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learning_rate   <= 25'd16777;
      cfg.beta_one        <= 25'd16106127;
      cfg.beta_two        <= 25'd16760439;
      cfg.curvature_floor <= 25'd1;
      cfg.clip_limit      <= 31'd16777216;
      cfg.decay_rate      <= 25'd0;
      cfg.bias_correction <= 25'd1677722;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEARNING_RATE:   cfg.learning_rate   <= cfg_data[24:0];
        REG_BETA_ONE:        cfg.beta_one        <= cfg_data[24:0];
        REG_BETA_TWO:        cfg.beta_two        <= cfg_data[24:0];
        REG_CURVATURE_FLOOR: cfg.curvature_floor <= cfg_data[24:0];
        REG_CLIP_LIMIT:      cfg.clip_limit      <= cfg_data;
        REG_DECAY_RATE:      cfg.decay_rate      <= cfg_data[24:0];
        REG_BIAS_CORRECTION: cfg.bias_correction <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // Front end: accept and form state-free products.
  sou_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .status     (status),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decoupling queue.
  sou_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: store update, division, clipping and parameter step.
  sou_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .status       (status),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// Optimizer update engine testbench
// Drives element updates through the item channel with random gaps, predicts
// the momentum, curvature and parameter update of every transfer, and checks
// each result in order. Configuration is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Predicts the update of each element and checks results in arrival order.
class update_scoreboard;
  logic signed [63:0] momentum_mem [sou_pkg::DEPTH];
  logic signed [63:0] curvature_mem [sou_pkg::DEPTH];
  sou_pkg::cfg_t cfg;
  sou_pkg::result_t pending_results[$];
  int errors;
  int checked;
  int clip_count;

  function new();
    foreach (momentum_mem[i]) begin
      momentum_mem[i] = 0;
      curvature_mem[i] = 0;
    end
    cfg.learning_rate = 25'd16777;
    cfg.beta_one = 25'd16106127;
    cfg.beta_two = 25'd16760439;
    cfg.curvature_floor = 25'd1;
    cfg.clip_limit = 31'd16777216;
    cfg.decay_rate = 25'd0;
    cfg.bias_correction = 25'd1677722;
    errors = 0;
    checked = 0;
    clip_count = 0;
  endfunction

  function void write_reg(logic [2:0] index, logic [30:0] value);
    case (index)
      sou_pkg::REG_LEARNING_RATE:   cfg.learning_rate = value[24:0];
      sou_pkg::REG_BETA_ONE:        cfg.beta_one = value[24:0];
      sou_pkg::REG_BETA_TWO:        cfg.beta_two = value[24:0];
      sou_pkg::REG_CURVATURE_FLOOR: cfg.curvature_floor = value[24:0];
      sou_pkg::REG_CLIP_LIMIT:      cfg.clip_limit = value;
      sou_pkg::REG_DECAY_RATE:      cfg.decay_rate = value[24:0];
      sou_pkg::REG_BIAS_CORRECTION: cfg.bias_correction = value[24:0];
      default: ;
    endcase
  endfunction

  static function logic signed [63:0] clamp_word(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Fixed-point product rounded toward minus infinity, then saturated.
  static function logic signed [63:0] fix_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return clamp_word(p >>> 24);
  endfunction

  function void note_item(sou_pkg::item_t it);
    logic signed [63:0] one, g, p, hx, b1, b2, bc, fl, rho;
    logic signed [63:0] m, m_hat, hd, h, divisor, ratio, upd, np;
    sou_pkg::result_t r;
    int idx;
    one = 64'sd16777216;
    idx = int'(it.element_index);
    g = 64'(it.gradient);
    p = 64'(it.param_value);
    hx = 64'(it.hessian_diag);
    b1 = {39'd0, cfg.beta_one};
    b2 = {39'd0, cfg.beta_two};
    bc = (cfg.bias_correction == 0) ? 64'sd1 : {39'd0, cfg.bias_correction};
    fl = (cfg.curvature_floor == 0) ? 64'sd1 : {39'd0, cfg.curvature_floor};
    rho = {33'd0, cfg.clip_limit};
    m = clamp_word(fix_mul(b1, momentum_mem[idx]) + fix_mul(one - b1, g));
    m_hat = clamp_word((m * one) / bc);
    hd = it.mode ? hx : fix_mul(g, g);
    h = clamp_word(fix_mul(b2, curvature_mem[idx]) + fix_mul(one - b2, hd));
    divisor = (h > fl) ? h : fl;
    ratio = (m_hat * one) / divisor;
    r.was_clipped = 1'b0;
    if (ratio > rho) begin
      ratio = rho;
      r.was_clipped = 1'b1;
    end else if (ratio < -rho) begin
      ratio = -rho;
      r.was_clipped = 1'b1;
    end
    upd = clamp_word(ratio + fix_mul({39'd0, cfg.decay_rate}, p));
    np = clamp_word(p - fix_mul({39'd0, cfg.learning_rate}, upd));
    momentum_mem[idx] = m;
    curvature_mem[idx] = h;
    r.result_index = it.element_index;
    r.new_param = np[31:0];
    r.new_momentum = m[31:0];
    r.new_curvature = h[31:0];
    pending_results.insert(pending_results.size(), r);
  endfunction

  function void check_result(sou_pkg::result_t act);
    sou_pkg::result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("unexpected result for index %0d", act.result_index);
      errors++;
      return;
    end
    exp_r = pending_results.pop_front();
    checked++;
    if (act.was_clipped) clip_count++;
    if (act.result_index !== exp_r.result_index) begin
      $error("result_index: expected %0d, got %0d", exp_r.result_index, act.result_index);
      errors++;
    end
    if (act.new_param !== exp_r.new_param) begin
      $error("new_param: expected %0d, got %0d", exp_r.new_param, act.new_param);
      errors++;
    end
    if (act.new_momentum !== exp_r.new_momentum) begin
      $error("new_momentum: expected %0d, got %0d", exp_r.new_momentum, act.new_momentum);
      errors++;
    end
    if (act.new_curvature !== exp_r.new_curvature) begin
      $error("new_curvature: expected %0d, got %0d", exp_r.new_curvature, act.new_curvature);
      errors++;
    end
    if (act.was_clipped !== exp_r.was_clipped) begin
      $error("was_clipped: expected %0b, got %0b", exp_r.was_clipped, act.was_clipped);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import sou_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;
  logic item_valid;
  logic item_ready;
  item_t item;
  logic result_valid;
  logic result_ready;
  result_t result;

  update_scoreboard sb;
  int cycle_count;
  int hold_off_cycles;
  bit stim_done;
  int item_count;

  sophia_optimizer_update dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Transfers are noted and checked at the sampling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) begin
        sb.note_item(item);
        item_count++;
      end
      if (result_valid && result_ready) sb.check_result(result);
    end
  end

  // Short gaps mostly, long ones now and then.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int g;
    result_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        result_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      g = (stim_done || item_count < 30) ? 0 : gap_len();
      if (g > 0) begin
        result_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_item(item_t it, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic stop_items();
    item_valid <= 1'b0;
  endtask

  // Waits until every expected result is back, then lets the pipe drain.
  task automatic drain();
    stop_items();
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [30:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    sb.write_reg(index, value);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4: return $signed($urandom());
      default: return $signed($urandom_range(0, 33554432)) - 32'sd16777216;
    endcase
  endfunction

  function automatic item_t rand_item(int idx_span);
    item_t it;
    it.element_index = (idx_span >= 4096) ? 12'($urandom()) : 12'($urandom_range(0, idx_span - 1));
    it.mode = 1'($urandom_range(0, 1));
    it.gradient = rand_word();
    it.param_value = rand_word();
    it.hessian_diag = rand_word();
    return it;
  endfunction

  task automatic random_phase(int count, int idx_span);
    repeat (count) send_item(rand_item(idx_span), 1'b1);
    drain();
  endtask

  function automatic item_t make_item(int idx, bit md, int g, int p, int hx);
    item_t it;
    it.element_index = idx[11:0];
    it.mode = md;
    it.gradient = g;
    it.param_value = p;
    it.hessian_diag = hx;
    return it;
  endfunction

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_LEARNING_RATE;
    cfg_data = '0;
    item_valid = 1'b0;
    item = '0;
    hold_off_cycles = 0;
    stim_done = 1'b0;
    item_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, both modes, repeated elements, negative Hessian.
    send_item(make_item(0, 0, 0, 0, 0), 1'b0);
    send_item(make_item(4095, 0, 32'h7fffffff, 32'h7fffffff, 0), 1'b0);
    send_item(make_item(4095, 1, 32'h80000000, 32'h80000000, 32'h7fffffff), 1'b0);
    send_item(make_item(4095, 1, 16777216, -16777216, 32'h80000000), 1'b0);
    send_item(make_item(1, 1, -16777216, 16777216, -5000000), 1'b0);
    send_item(make_item(1, 0, 16777216, 0, 0), 1'b0);
    send_item(make_item(1, 0, -1, -1, -1), 1'b0);
    send_item(make_item(2, 0, 1, 1, 1), 1'b0);
    send_item(make_item(2730, 1, 32'h55555555, 32'haaaaaaaa, 32'h55555555), 1'b0);
    send_item(make_item(1365, 0, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa), 1'b0);
    drain();

    // Zero floor and bias correction, factors above one, all extremes.
    write_reg(REG_CURVATURE_FLOOR, 31'd0);
    write_reg(REG_BIAS_CORRECTION, 31'd0);
    write_reg(REG_BETA_ONE, 31'd33554431);
    write_reg(REG_BETA_TWO, 31'd33554431);
    write_reg(REG_CLIP_LIMIT, 31'h7fffffff);
    write_reg(REG_DECAY_RATE, 31'd33554431);
    write_reg(REG_LEARNING_RATE, 31'd33554431);
    send_item(make_item(3, 0, 16777216, 16777216, 0), 1'b0);
    send_item(make_item(3, 1, -16777216, -16777216, -16777216), 1'b0);
    send_item(make_item(4, 1, 32'h7fffffff, 32'h80000000, 32'h80000000), 1'b0);
    random_phase(150, 16);

    // Lower extremes: zero factors, zero clip limit.
    write_reg(REG_BETA_ONE, 31'd0);
    write_reg(REG_BETA_TWO, 31'd0);
    write_reg(REG_CLIP_LIMIT, 31'd0);
    write_reg(REG_DECAY_RATE, 31'd0);
    write_reg(REG_LEARNING_RATE, 31'd0);
    write_reg(REG_CURVATURE_FLOOR, 31'd16777216);
    write_reg(REG_BIAS_CORRECTION, 31'd16777216);
    random_phase(150, 4096);

    // Typical training settings with hot indexes; one long receiver stall.
    write_reg(REG_LEARNING_RATE, 31'd16777);
    write_reg(REG_BETA_ONE, 31'd16106127);
    write_reg(REG_BETA_TWO, 31'd16760439);
    write_reg(REG_CURVATURE_FLOOR, 31'd1677);
    write_reg(REG_CLIP_LIMIT, 31'd16777216);
    write_reg(REG_DECAY_RATE, 31'd1677);
    write_reg(REG_BIAS_CORRECTION, 31'd1677722);
    hold_off_cycles = 300;
    repeat (100) send_item(rand_item(8), 1'b0);
    random_phase(250, 8);

    // Random configuration each phase.
    repeat (3) begin
      write_reg(REG_LEARNING_RATE, 31'($urandom_range(0, 16777216)));
      write_reg(REG_BETA_ONE, 31'($urandom_range(0, 16777216)));
      write_reg(REG_BETA_TWO, 31'($urandom_range(0, 16777216)));
      write_reg(REG_CURVATURE_FLOOR, 31'($urandom_range(1, 16777216)));
      write_reg(REG_CLIP_LIMIT, 31'($urandom_range(0, 32'h7fffffff)));
      write_reg(REG_DECAY_RATE, 31'($urandom_range(0, 16777216)));
      write_reg(REG_BIAS_CORRECTION, 31'($urandom_range(1, 16777216)));
      random_phase(110, ($urandom_range(0, 1) == 1) ? 32 : 4096);
    end

    stim_done = 1'b1;
    drain();
    $display("Checked %0d element updates (%0d clipped) over several register settings.",
             sb.checked, sb.clip_count);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
